FILE: src/mrfe_pkg.sv
// ----------------------------------------------------------------------------
// mrfe_pkg
// shared types and constants of the modbus rtu master frame engine
// ----------------------------------------------------------------------------
package mrfe_pkg;

    // crc-16 (reflected polynomial, all-ones start)
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // default read limit in registers
    localparam int MAX_REGS_DEF = 16;

    // command word for the shared crc unit
    typedef struct packed {
        logic       init;   // restart at CRC_INIT
        logic       load;   // fold a byte into the low bits
        logic       step;   // one bit of the polynomial division
        logic [7:0] data;
    } t_crc_cmd;

endpackage

FILE: src/mrfe_crc_unit.sv
// ----------------------------------------------------------------------------
// mrfe_crc_unit
// bit-serial crc-16 register shared by the transmit and receive paths
// ----------------------------------------------------------------------------
module mrfe_crc_unit
    import mrfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_cmd    i_cmd,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] base;

    // load folds a byte into either the running value or a fresh start
    always_comb begin
        base  = i_cmd.init ? CRC_INIT : r_crc;
        n_crc = r_crc;
        if (i_cmd.step) begin
            n_crc = r_crc[0] ? ((r_crc >> 1) ^ CRC_POLY) : (r_crc >> 1);
        end else if (i_cmd.load) begin
            n_crc = base ^ {8'h00, i_cmd.data};
        end else if (i_cmd.init) begin
            n_crc = CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

FILE: src/modbus_rtu_master_frame_engine.sv
// ----------------------------------------------------------------------------
// modbus_rtu_master_frame_engine
// modbus rtu master: builds requests with crc-16, checks responses and
// releases read register words followed by one status
// ----------------------------------------------------------------------------
//  channel   | dir | fields
//  s_axis    | in  | tuser operation, tdata func/addr/arg/rx byte, tlast rx_last
//  m_axis    | out | tuser kind, tdata tx/word/status/exception, tlast last
//  apb       | in  | slave_addr at byte address 0
//
//  an issue folds the six request bytes into the shared crc unit one bit a
//  cycle, sends each after its fold, then sends the two crc bytes
//  a received byte is folded the same way; the final byte adds a judging
//  step, and each released read word a registered word buffer read
//  synchronous active-low reset; no clearing pass
//  a stalled output holds the sequencer at its emit step only
// ----------------------------------------------------------------------------
module modbus_rtu_master_frame_engine
    import mrfe_pkg::*;
#(
    parameter int MAX_REGS = MAX_REGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request and response stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // func_code, reg_addr, reg_arg, rx_byte
    input  logic [1:0]  s_axis_tuser,   // operation
    input  logic        s_axis_tlast,   // rx_last
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // tx_byte, reg_word, status, exception_code
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CW = $clog2(MAX_REGS + 1);
    localparam logic [7:0] BUF_READ  = 8'(5 + 2 * MAX_REGS);
    localparam logic [7:0] BUF_WRITE = 8'd8;

    // operations, kinds, statuses, function codes
    localparam logic [1:0] OP_ISSUE   = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_CRC       = 3'd3;
    localparam logic [2:0] ST_ADDR      = 3'd4;
    localparam logic [2:0] ST_EXCEPTION = 3'd5;
    localparam logic [2:0] ST_BAD       = 3'd6;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd7;
    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_READ_INPUT  = 8'h04;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] EXC_BIT        = 8'h80;
    localparam logic       REG_SLAVE_ADDR = 1'b0;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_TX_SHIFT = 3'd1;
    localparam logic [2:0] S_TX_EMIT  = 3'd2;
    localparam logic [2:0] S_RX_SHIFT = 3'd3;
    localparam logic [2:0] S_JUDGE    = 3'd4;
    localparam logic [2:0] S_WRD_RD   = 3'd5;
    localparam logic [2:0] S_WRD_OUT  = 3'd6;
    localparam logic [2:0] S_STATUS   = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_bit, n_bit;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_pf, n_pf;
    logic [15:0] r_pa, n_pa;
    logic [15:0] r_parg, n_parg;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_hdr [3];
    logic [7:0]  n_hdr [3];
    logic        r_echo, n_echo;
    logic [7:0]  r_hi, n_hi;
    logic        r_last_in, n_last_in;
    logic [CW-1:0] r_widx, n_widx;
    logic [2:0]  r_status, n_status;
    logic [7:0]  r_exc, n_exc;
    logic [7:0]  r_slave;
    logic [15:0] r_rdata;
    logic [15:0] r_mem [MAX_REGS];

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_kind, n_out_kind;
    logic [7:0]  r_out_tx, n_out_tx;
    logic [15:0] r_out_word, n_out_word;
    logic [2:0]  r_out_status, n_out_status;
    logic [7:0]  r_out_exc, n_out_exc;
    logic        r_out_last, n_out_last;

    t_crc_cmd    crc_cmd;
    logic [15:0] crc_val;

    // input fields
    logic [1:0]  in_op;
    logic [7:0]  in_fc, in_rb;
    logic [15:0] in_ra, in_arg;
    logic        accept, out_free, issue_ok, in_is_read;

    // receive bookkeeping
    logic [7:0]  rx_limit, rx_off, echo_want, frame_byte, exp_len;
    logic        echo_chk;
    logic [6:0]  rx_word;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0] mem_wdata;

    // judging
    logic        pend_read, read_bad, j_words;
    logic [2:0]  j_status;

    assign in_op  = s_axis_tuser;
    assign in_fc  = s_axis_tdata[7:0];
    assign in_ra  = s_axis_tdata[23:8];
    assign in_arg = s_axis_tdata[39:24];
    assign in_rb  = s_axis_tdata[47:40];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign in_is_read = (in_fc == FC_READ_HOLD) || (in_fc == FC_READ_INPUT);
    assign issue_ok   = (in_is_read && (in_arg <= 16'(MAX_REGS))) ||
                        (in_fc == FC_WRITE_SINGLE);

    // shared crc unit
    mrfe_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (crc_cmd),
        .o_crc   (crc_val)
    );

    // request frame byte by position
    always_comb begin
        unique case (r_idx)
            3'd0:    frame_byte = r_slave;
            3'd1:    frame_byte = r_pf;
            3'd2:    frame_byte = r_pa[15:8];
            3'd3:    frame_byte = r_pa[7:0];
            3'd4:    frame_byte = r_parg[15:8];
            3'd5:    frame_byte = r_parg[7:0];
            3'd6:    frame_byte = crc_val[7:0];
            default: frame_byte = crc_val[15:8];
        endcase
    end

    // echo byte expected at positions 2 to 5 of a write response
    always_comb begin
        echo_chk  = 1'b1;
        echo_want = 8'h00;
        case (r_count)
            8'd2:    echo_want = r_pa[15:8];
            8'd3:    echo_want = r_pa[7:0];
            8'd4:    echo_want = r_parg[15:8];
            8'd5:    echo_want = r_parg[7:0];
            default: echo_chk  = 1'b0;
        endcase
    end

    assign rx_limit = (r_pf == FC_WRITE_SINGLE) ? BUF_WRITE : BUF_READ;
    assign rx_off   = r_count - 8'd3;
    assign rx_word  = rx_off[7:1];

    // response judgement, first failing check wins
    assign pend_read = (r_pf == FC_READ_HOLD) || (r_pf == FC_READ_INPUT);
    assign exp_len   = 8'd5 + {r_parg[6:0], 1'b0};
    assign read_bad  = (r_count != exp_len) || (r_hdr[1] != r_pf) ||
                       (r_hdr[2] != {r_parg[6:0], 1'b0});

    always_comb begin
        j_words = 1'b0;
        if (r_count < 8'd4) begin
            j_status = ST_SHORT;
        end else if (crc_val != 16'h0000) begin
            j_status = ST_CRC;
        end else if (r_hdr[0] != r_slave) begin
            j_status = ST_ADDR;
        end else if ((r_hdr[1] & EXC_BIT) != 8'h00) begin
            j_status = ST_EXCEPTION;
        end else if (pend_read && (r_parg <= 16'(MAX_REGS))) begin
            j_status = read_bad ? ST_BAD : ST_OK;
            j_words  = !read_bad && (r_parg != 16'h0000);
        end else if (r_pf == FC_WRITE_SINGLE) begin
            j_status = ((r_count == 8'd8) && (r_hdr[1] == FC_WRITE_SINGLE) && r_echo) ?
                       ST_OK : ST_BAD;
        end else begin
            j_status = ST_BAD;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_idx       = r_idx;
        n_pf        = r_pf;
        n_pa        = r_pa;
        n_parg      = r_parg;
        n_count     = r_count;
        n_hdr       = r_hdr;
        n_echo      = r_echo;
        n_hi        = r_hi;
        n_last_in   = r_last_in;
        n_widx      = r_widx;
        n_status    = r_status;
        n_exc       = r_exc;
        crc_cmd     = '0;
        mem_we      = 1'b0;
        mem_addr    = rx_word[AW-1:0];
        mem_wdata   = {r_hi, in_rb};

        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_tx     = r_out_tx;
        n_out_word   = r_out_word;
        n_out_status = r_out_status;
        n_out_exc    = r_out_exc;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_ISSUE: begin
                            if (issue_ok) begin
                                n_pf    = in_fc;
                                n_pa    = in_ra;
                                n_parg  = in_arg;
                                n_count = 8'd0;
                                n_hdr   = '{default: 8'h00};
                                n_echo  = 1'b1;
                                n_idx   = 3'd0;
                                n_bit   = 3'd0;
                                crc_cmd.init = 1'b1;
                                crc_cmd.load = 1'b1;
                                crc_cmd.data = r_slave;
                                n_state = S_TX_SHIFT;
                            end else begin
                                n_status = ST_BAD_SIZE;
                                n_exc    = 8'h00;
                                n_state  = S_STATUS;
                            end
                        end
                        OP_RX_BYTE: begin
                            n_last_in = s_axis_tlast;
                            if (r_count < rx_limit) begin
                                if (r_count < 8'd3) begin
                                    n_hdr[r_count[1:0]] = in_rb;
                                end
                                if (echo_chk && (in_rb != echo_want)) begin
                                    n_echo = 1'b0;
                                end
                                if (r_count >= 8'd3) begin
                                    if (!rx_off[0]) begin
                                        n_hi = in_rb;
                                    end else if (rx_word < 7'(MAX_REGS)) begin
                                        mem_we = 1'b1;
                                    end
                                end
                                n_count      = r_count + 8'd1;
                                crc_cmd.load = 1'b1;
                                crc_cmd.data = in_rb;
                                n_bit        = 3'd0;
                                n_state      = S_RX_SHIFT;
                            end else if (s_axis_tlast) begin
                                n_state = S_JUDGE;
                            end
                        end
                        OP_TIMEOUT: begin
                            n_count      = 8'd0;
                            n_hdr        = '{default: 8'h00};
                            n_echo       = 1'b1;
                            crc_cmd.init = 1'b1;
                            n_status     = ST_TIMEOUT;
                            n_exc        = 8'h00;
                            n_state      = S_STATUS;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_TX_SHIFT: begin
                crc_cmd.step = 1'b1;
                n_bit        = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = S_TX_EMIT;
                end
            end

            S_TX_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_TX;
                    n_out_tx     = frame_byte;
                    n_out_word   = 16'h0000;
                    n_out_status = ST_OK;
                    n_out_exc    = 8'h00;
                    n_out_last   = (r_idx == 3'd7);
                    n_idx        = r_idx + 3'd1;
                    if (r_idx < 3'd5) begin
                        // fold the next header byte and run its eight steps
                        unique case (r_idx)
                            3'd0:    crc_cmd.data = r_pf;
                            3'd1:    crc_cmd.data = r_pa[15:8];
                            3'd2:    crc_cmd.data = r_pa[7:0];
                            3'd3:    crc_cmd.data = r_parg[15:8];
                            default: crc_cmd.data = r_parg[7:0];
                        endcase
                        crc_cmd.load = 1'b1;
                        n_bit        = 3'd0;
                        n_state      = S_TX_SHIFT;
                    end else if (r_idx == 3'd7) begin
                        crc_cmd.init = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end

            S_RX_SHIFT: begin
                crc_cmd.step = 1'b1;
                n_bit        = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = r_last_in ? S_JUDGE : S_IDLE;
                end
            end

            S_JUDGE: begin
                n_status     = j_status;
                n_exc        = (j_status == ST_EXCEPTION) ? r_hdr[2] : 8'h00;
                n_widx       = '0;
                n_count      = 8'd0;
                n_hdr        = '{default: 8'h00};
                n_echo       = 1'b1;
                crc_cmd.init = 1'b1;
                n_state      = j_words ? S_WRD_RD : S_STATUS;
            end

            S_WRD_RD: begin
                n_state = S_WRD_OUT;
            end

            S_WRD_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_WORD;
                    n_out_tx     = 8'h00;
                    n_out_word   = r_rdata;
                    n_out_status = ST_OK;
                    n_out_exc    = 8'h00;
                    n_out_last   = 1'b0;
                    if (({1'b0, r_widx} + (CW + 1)'(1)) == r_parg[CW:0]) begin
                        n_state = S_STATUS;
                    end else begin
                        n_widx  = r_widx + CW'(1);
                        n_state = S_WRD_RD;
                    end
                end
            end

            S_STATUS: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_STATUS;
                    n_out_tx     = 8'h00;
                    n_out_word   = 16'h0000;
                    n_out_status = r_status;
                    n_out_exc    = r_exc;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and receive state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= 3'd0;
            r_idx       <= 3'd0;
            r_pf        <= 8'h00;
            r_pa        <= 16'h0000;
            r_parg      <= 16'h0000;
            r_count     <= 8'd0;
            r_hdr       <= '{default: 8'h00};
            r_echo      <= 1'b1;
            r_last_in   <= 1'b0;
            r_widx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_idx       <= n_idx;
            r_pf        <= n_pf;
            r_pa        <= n_pa;
            r_parg      <= n_parg;
            r_count     <= n_count;
            r_hdr       <= n_hdr;
            r_echo      <= n_echo;
            r_last_in   <= n_last_in;
            r_widx      <= n_widx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hi         <= n_hi;
        r_status     <= n_status;
        r_exc        <= n_exc;
        r_out_kind   <= n_out_kind;
        r_out_tx     <= n_out_tx;
        r_out_word   <= n_out_word;
        r_out_status <= n_out_status;
        r_out_exc    <= n_out_exc;
        r_out_last   <= n_out_last;
    end

    // read word buffer, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_widx[AW-1:0]];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave <= 8'd1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SLAVE_ADDR)) begin
            r_slave <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLAVE_ADDR) ? {24'h000000, r_slave} : 32'h00000000;

    // result port
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'b00000, r_out_exc, r_out_status, r_out_word, r_out_tx};

    // a judged response always leaves the receive state cleared
    a_judge_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JUDGE) |=> (r_count == 8'd0) && r_echo)
        else $error("receive state not cleared after judging");

    // the crc register restarts once the last request byte goes out
    a_tx_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TX_EMIT && r_idx == 3'd7 && out_free) |=> (crc_val == CRC_INIT))
        else $error("crc not restarted after request frame");

    // word release never reads beyond the buffer
    a_word_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRD_OUT) |-> ({1'b0, r_widx} < (CW + 1)'(MAX_REGS)))
        else $error("word index beyond buffer");

endmodule
